>>> src/imsf_pkg.sv
// Shared types and constants for the Ising Metropolis spin-flip block.
// Holds field widths, threshold reset values, controller states and the
// command/status structs between controller and datapath. No dependencies.
package imsf_pkg;

    // Default geometry and random width
    localparam int LATTICE_WIDTH_DEF = 64;
    localparam int INTERIOR_ROWS_DEF = 64;
    localparam int RANDOM_BITS_DEF   = 16;

    // Fixed field widths
    localparam int THRESH_W   = 17;
    localparam int ENERGY_W   = 5;
    localparam int MAG_W      = 14;
    localparam int NUM_THRESH = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int IDX_W      = 3;

    // Result word: flipped, new_spin, energy_change, magnetization
    localparam int OUT_BITS   = 1 + 1 + ENERGY_W + MAG_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // Threshold registers after reset, by register index
    localparam logic [THRESH_W-1:0] THRESH_RESET [NUM_THRESH] = '{
        17'd65536, 17'd65536, 17'd65536, 17'd8869, 17'd1200
    };

    // Item function codes
    localparam logic FUNC_SET  = 1'b0;
    localparam logic FUNC_FLIP = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_BELOW,
        ST_RD_CENTER,
        ST_RD_ABOVE,
        ST_COMMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic clear_wr;
        logic load_item;
        logic rd_below;
        logic rd_center;
        logic rd_above;
        logic latch_below;
        logic latch_center;
        logic commit;
    } t_ctrl_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clear_done;
        logic site_ok;
        logic out_free;
    } t_dp_status;

endpackage

>>> src/imsf_ctrl.sv
// Sequencer for the spin-flip block: clearing pass, item intake, three row
// reads and the commit step. Depends on imsf_pkg.
module imsf_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  imsf_pkg::t_dp_status   i_sts,
    output imsf_pkg::t_ctrl_cmd    o_cmd
);

    imsf_pkg::t_state r_state;
    imsf_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= imsf_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            imsf_pkg::ST_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_sts.clear_done) begin
                    n_state = imsf_pkg::ST_IDLE;
                end
            end
            imsf_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = imsf_pkg::ST_RD_BELOW;
                end
            end
            imsf_pkg::ST_RD_BELOW: begin
                // skip the reads for a site outside the interior
                if (i_sts.site_ok) begin
                    o_cmd.rd_below = 1'b1;
                    n_state        = imsf_pkg::ST_RD_CENTER;
                end else begin
                    n_state = imsf_pkg::ST_COMMIT;
                end
            end
            imsf_pkg::ST_RD_CENTER: begin
                o_cmd.latch_below = 1'b1;
                o_cmd.rd_center   = 1'b1;
                n_state           = imsf_pkg::ST_RD_ABOVE;
            end
            imsf_pkg::ST_RD_ABOVE: begin
                o_cmd.latch_center = 1'b1;
                o_cmd.rd_above     = 1'b1;
                n_state            = imsf_pkg::ST_COMMIT;
            end
            imsf_pkg::ST_COMMIT: begin
                // hold until the result register can take the word
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = imsf_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = imsf_pkg::ST_IDLE;
            end
        endcase
    end

    a_commit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> i_sts.out_free)
        else $error("commit while result register is full");

    a_one_item_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_item |=> !o_s_tready)
        else $error("second word taken while an item is in work");

endmodule

>>> src/imsf_datapath.sv
// Datapath of the spin-flip block: lattice row memory, threshold registers,
// local field, acceptance compare, magnetization and result register.
// Depends on imsf_pkg; driven by imsf_ctrl.
module imsf_datapath #(
    parameter int  LATTICE_WIDTH = imsf_pkg::LATTICE_WIDTH_DEF,
    parameter int  INTERIOR_ROWS = imsf_pkg::INTERIOR_ROWS_DEF,
    parameter int  RANDOM_BITS   = imsf_pkg::RANDOM_BITS_DEF,
    localparam int XW            = $clog2(LATTICE_WIDTH),
    localparam int YW            = $clog2(INTERIOR_ROWS + 2)
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  imsf_pkg::t_ctrl_cmd                   i_cmd,
    output imsf_pkg::t_dp_status                  o_sts,
    input  logic                                  i_func,
    input  logic [XW-1:0]                         i_site_x,
    input  logic [YW-1:0]                         i_site_y,
    input  logic                                  i_spin_value,
    input  logic [RANDOM_BITS-1:0]                i_random_fraction,
    input  logic                                  i_cfg_wr,
    input  logic [imsf_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [imsf_pkg::THRESH_W-1:0]         i_cfg_data,
    input  logic                                  i_m_tready,
    output logic                                  o_m_tvalid,
    output logic                                  o_flipped,
    output logic                                  o_new_spin,
    output logic signed [imsf_pkg::ENERGY_W-1:0]  o_energy_change,
    output logic signed [imsf_pkg::MAG_W-1:0]     o_magnetization
);

    localparam int AW       = $clog2(INTERIOR_ROWS);
    localparam int CMP_W    = (RANDOM_BITS > imsf_pkg::THRESH_W) ? RANDOM_BITS
                                                                 : imsf_pkg::THRESH_W;
    localparam int MAG_INIT = -(LATTICE_WIDTH * INTERIOR_ROWS);

    // Item registers
    logic                   r_func;
    logic [XW-1:0]          r_x;
    logic [YW-1:0]          r_y;
    logic                   r_sv;
    logic [RANDOM_BITS-1:0] r_rnd;

    // Lattice memory and row buffers
    logic [LATTICE_WIDTH-1:0] r_lattice [INTERIOR_ROWS];
    logic [LATTICE_WIDTH-1:0] r_rd_data;
    logic [LATTICE_WIDTH-1:0] r_below;
    logic [LATTICE_WIDTH-1:0] r_center;
    logic [AW-1:0]            r_clr_addr;

    logic [imsf_pkg::THRESH_W-1:0] r_thresh [imsf_pkg::NUM_THRESH];
    logic signed [imsf_pkg::MAG_W-1:0] r_mag;
    logic signed [imsf_pkg::MAG_W-1:0] n_mag;

    // Result register
    logic                                 r_out_valid;
    logic                                 r_out_flipped;
    logic                                 r_out_spin;
    logic signed [imsf_pkg::ENERGY_W-1:0] r_out_energy;

    logic                     x_ok;
    logic                     y_ok;
    logic                     site_ok;
    logic                     has_below;
    logic                     has_above;
    logic [AW-1:0]            center_addr;
    logic [AW-1:0]            below_addr;
    logic [AW-1:0]            above_addr;
    logic [AW-1:0]            rd_addr;
    logic                     rd_en;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic [LATTICE_WIDTH-1:0] wr_data;
    logic [LATTICE_WIDTH-1:0] wr_row;
    logic [LATTICE_WIDTH-1:0] above_row;
    logic [XW-1:0]            x_left;
    logic [XW-1:0]            x_right;
    logic                     spin;
    logic [imsf_pkg::IDX_W-1:0] up_count;
    logic [imsf_pkg::IDX_W-1:0] th_idx;
    logic                     accept;
    logic                     c_flipped;
    logic                     c_spin;
    logic                     c_changed;
    logic signed [imsf_pkg::ENERGY_W-1:0] c_energy;

    // Site range checks
    assign x_ok    = {1'b0, r_x} < (XW + 1)'(LATTICE_WIDTH);
    assign y_ok    = (r_y != '0) && (r_y <= YW'(INTERIOR_ROWS));
    assign site_ok = x_ok && y_ok;

    // Row addresses; boundary rows come from constants, not the memory
    assign has_below   = (r_y != YW'(1));
    assign has_above   = (r_y != YW'(INTERIOR_ROWS));
    assign center_addr = AW'(r_y - YW'(1));
    assign below_addr  = has_below ? AW'(r_y - YW'(2)) : '0;
    assign above_addr  = has_above ? AW'(r_y) : '0;
    assign rd_en       = i_cmd.rd_below | i_cmd.rd_center | i_cmd.rd_above;
    assign rd_addr     = i_cmd.rd_below  ? below_addr :
                         i_cmd.rd_center ? center_addr : above_addr;
    assign above_row   = has_above ? r_rd_data : '1;

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_func <= i_func;
            r_x    <= i_site_x;
            r_y    <= i_site_y;
            r_sv   <= i_spin_value;
            r_rnd  <= i_random_fraction;
        end
    end

    // Lattice memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_lattice[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_lattice[rd_addr];
        end
    end

    // Latch the row below and the center row
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_below) begin
            r_below <= has_below ? r_rd_data : '0;
        end
        if (i_cmd.latch_center) begin
            r_center <= r_rd_data;
        end
    end

    // Clearing pass address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear_wr) begin
            r_clr_addr <= r_clr_addr + AW'(1);
        end
    end

    // Threshold registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < imsf_pkg::NUM_THRESH; i++) begin
                r_thresh[i] <= imsf_pkg::THRESH_RESET[i];
            end
        end else if (i_cfg_wr && (i_cfg_index < imsf_pkg::CFG_IDX_W'(imsf_pkg::NUM_THRESH))) begin
            r_thresh[i_cfg_index] <= i_cfg_data;
        end
    end

    // Local field: count up neighbors, fold with the site's spin
    always_comb begin
        x_left   = (r_x == '0) ? XW'(LATTICE_WIDTH - 1) : r_x - XW'(1);
        x_right  = (r_x == XW'(LATTICE_WIDTH - 1)) ? '0 : r_x + XW'(1);
        spin     = r_center[r_x];
        up_count = imsf_pkg::IDX_W'(r_center[x_left]) + imsf_pkg::IDX_W'(r_center[x_right])
                 + imsf_pkg::IDX_W'(r_below[r_x]) + imsf_pkg::IDX_W'(above_row[r_x]);
        th_idx   = spin ? up_count : imsf_pkg::IDX_W'(4) - up_count;
        accept   = CMP_W'(r_rnd) < CMP_W'(r_thresh[th_idx]);
    end

    // Step outcome
    always_comb begin
        c_flipped = 1'b0;
        c_spin    = 1'b0;
        c_changed = 1'b0;
        c_energy  = '0;
        if (!site_ok) begin
            c_spin = x_ok && (r_y == YW'(INTERIOR_ROWS + 1));
        end else if (r_func == imsf_pkg::FUNC_SET) begin
            c_spin    = r_sv;
            c_changed = (spin != r_sv);
        end else begin
            c_flipped = accept;
            c_spin    = spin ^ accept;
            c_changed = accept;
            // energy change is 2*h = 4*idx - 8
            if (accept) begin
                c_energy = $signed({th_idx, 2'b00}) - imsf_pkg::ENERGY_W'(8);
            end
        end
    end

    // Center row with the site replaced
    always_comb begin
        for (int i = 0; i < LATTICE_WIDTH; i++) begin
            wr_row[i] = (XW'(i) == r_x) ? c_spin : r_center[i];
        end
    end

    assign wr_en   = i_cmd.clear_wr | (i_cmd.commit & site_ok);
    assign wr_addr = i_cmd.clear_wr ? r_clr_addr : center_addr;
    assign wr_data = i_cmd.clear_wr ? '0 : wr_row;

    // On a change, magnetization moves by two times the new spin
    always_comb begin
        n_mag = r_mag;
        if (i_cmd.commit && c_changed) begin
            n_mag = c_spin ? r_mag + imsf_pkg::MAG_W'(2) : r_mag - imsf_pkg::MAG_W'(2);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag <= imsf_pkg::MAG_W'(MAG_INIT);
        end else begin
            r_mag <= n_mag;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_flipped <= c_flipped;
            r_out_spin    <= c_spin;
            r_out_energy  <= c_energy;
        end
    end

    assign o_m_tvalid      = r_out_valid;
    assign o_flipped       = r_out_flipped;
    assign o_new_spin      = r_out_spin;
    assign o_energy_change = r_out_energy;
    assign o_magnetization = r_mag;

    assign o_sts.clear_done = (r_clr_addr == AW'(INTERIOR_ROWS - 1));
    assign o_sts.site_ok    = site_ok;
    assign o_sts.out_free   = !r_out_valid || i_m_tready;

    a_energy_only_on_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_flipped) |-> (r_out_energy == '0))
        else $error("energy change reported without a flip");

    a_flip_moves_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && c_flipped) |=> (r_mag != $past(r_mag)))
        else $error("accepted flip left magnetization unchanged");

    a_clear_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_wr |-> !rd_en)
        else $error("lattice read during clearing pass");

endmodule

>>> src/ising_metropolis_spin_flip.sv
// Top level of the Ising Metropolis spin-flip block: stream ports, config
// write port, field packing. Instantiates imsf_ctrl and imsf_datapath;
// depends on imsf_pkg.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------------
//  item in  | i_s_tvalid / o_s_tready    | i_s_tuser: func; i_s_tdata: site fields
//  result   | o_m_tvalid / i_m_tready    | o_m_tdata: flip, spin, energy, magnetization
//  config   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data (threshold)
//
// For a site inside the lattice, after acceptance the lattice memory reads
// the rows below, at and above the site through its one read port, one per
// cycle, then the updated row is written back as the result word is loaded.
// o_s_tready returns in the cycle after that. An item naming a site outside
// the interior skips the reads and goes straight to the commit step.
// After reset a clearing pass writes INTERIOR_ROWS rows, one per cycle, with
// o_s_tready low; config writes are taken at any time.
// A stalled result word holds the commit step until i_m_tready frees the register.
module ising_metropolis_spin_flip #(
    parameter int  LATTICE_WIDTH = imsf_pkg::LATTICE_WIDTH_DEF,
    parameter int  INTERIOR_ROWS = imsf_pkg::INTERIOR_ROWS_DEF,
    parameter int  RANDOM_BITS   = imsf_pkg::RANDOM_BITS_DEF,
    localparam int XW            = $clog2(LATTICE_WIDTH),
    localparam int YW            = $clog2(INTERIOR_ROWS + 2),
    localparam int IN_BITS       = XW + YW + 1 + RANDOM_BITS,
    localparam int IN_DATA_W     = ((IN_BITS + 7) / 8) * 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // site_x, site_y, spin_value, random_fraction (low to high), zero pad
    input  logic [IN_DATA_W-1:0]                i_s_tdata,
    // func
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // flipped, new_spin, energy_change, magnetization (low to high), zero pad
    output logic [imsf_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [imsf_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [imsf_pkg::THRESH_W-1:0]       i_cfg_data
);

    imsf_pkg::t_ctrl_cmd  cmd;
    imsf_pkg::t_dp_status sts;

    logic [XW-1:0]                        site_x;
    logic [YW-1:0]                        site_y;
    logic                                 spin_value;
    logic [RANDOM_BITS-1:0]               random_fraction;
    logic                                 flipped;
    logic                                 new_spin;
    logic signed [imsf_pkg::ENERGY_W-1:0] energy_change;
    logic signed [imsf_pkg::MAG_W-1:0]    magnetization;

    // Unpack the item word
    assign site_x          = i_s_tdata[XW-1:0];
    assign site_y          = i_s_tdata[XW +: YW];
    assign spin_value      = i_s_tdata[XW + YW];
    assign random_fraction = i_s_tdata[XW + YW + 1 +: RANDOM_BITS];

    // Pack the result word
    assign o_m_tdata = {{(imsf_pkg::OUT_DATA_W - imsf_pkg::OUT_BITS){1'b0}},
                        magnetization, energy_change, new_spin, flipped};

    // Threshold writes never stall
    assign o_cfg_ready = 1'b1;

    imsf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    imsf_datapath #(
        .LATTICE_WIDTH (LATTICE_WIDTH),
        .INTERIOR_ROWS (INTERIOR_ROWS),
        .RANDOM_BITS   (RANDOM_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_func            (i_s_tuser),
        .i_site_x          (site_x),
        .i_site_y          (site_y),
        .i_spin_value      (spin_value),
        .i_random_fraction (random_fraction),
        .i_cfg_wr          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_m_tready        (i_m_tready),
        .o_m_tvalid        (o_m_tvalid),
        .o_flipped         (flipped),
        .o_new_spin        (new_spin),
        .o_energy_change   (energy_change),
        .o_magnetization   (magnetization)
    );

endmodule

>>> sim/ising_metropolis_spin_flip_tb.sv
// Self-checking testbench for ising_metropolis_spin_flip: directed and random
// set/flip words checked against an in-bench lattice model held in a scoreboard.
// Depends on imsf_pkg and the ising_metropolis_spin_flip RTL only.
`timescale 1ns / 1ps

module ising_metropolis_spin_flip_tb;

    localparam int COLS      = 64;
    localparam int ROWS      = 64;
    localparam int IN_DATA_W = 32;
    localparam int ITEMS_PER_PHASE = 170;

    // Threshold register indexes
    localparam int REG_FIELD_MINUS4 = 0;
    localparam int REG_FIELD_MINUS2 = 1;
    localparam int REG_FIELD_ZERO   = 2;
    localparam int REG_FIELD_PLUS2  = 3;
    localparam int REG_FIELD_PLUS4  = 4;
    localparam int REG_UNMAPPED     = 7;

    localparam logic [imsf_pkg::THRESH_W-1:0] THRESH_ALWAYS = 17'd65536;
    localparam logic [imsf_pkg::THRESH_W-1:0] THRESH_MAX    = 17'h1FFFF;

    typedef struct packed {
        logic        func;
        logic [5:0]  site_x;
        logic [6:0]  site_y;
        logic        spin_value;
        logic [15:0] random_fraction;
    } t_spin_item;

    // Packed high to low so a cast from the low bits of o_m_tdata decodes it
    typedef struct packed {
        logic signed [imsf_pkg::MAG_W-1:0]    magnetization;
        logic signed [imsf_pkg::ENERGY_W-1:0] energy_change;
        logic                                 new_spin;
        logic                                 flipped;
    } t_flip_result;

    // Lattice model and queue of expected result words
    class t_spin_flip_scoreboard;
        bit [COLS-1:0]                 rows [1:ROWS];
        int                            mag;
        logic [imsf_pkg::THRESH_W-1:0] thresh [imsf_pkg::NUM_THRESH];
        t_flip_result                  expected_q [$];
        int                            errors;

        function new();
            for (int r = 1; r <= ROWS; r++) rows[r] = '0;
            for (int i = 0; i < imsf_pkg::NUM_THRESH; i++) thresh[i] = imsf_pkg::THRESH_RESET[i];
            mag    = -(COLS * ROWS);
            errors = 0;
        endfunction

        function void write_threshold(int idx, logic [imsf_pkg::THRESH_W-1:0] value);
            if (idx < imsf_pkg::NUM_THRESH) thresh[idx] = value;
        endfunction

        // Spin as +1/-1; row 0 is pinned low, the row past the interior high
        function int spin_at(int x, int y);
            if (y == 0) return -1;
            if (y > ROWS) return 1;
            return rows[y][x] ? 1 : -1;
        endfunction

        function void note_item(t_spin_item it);
            t_flip_result r;
            int x, y, xl, xr, s, nsum, h;
            x = it.site_x;
            y = it.site_y;
            r = '0;
            if (y == 0 || y > ROWS) begin
                r.new_spin = (y == ROWS + 1);
            end else if (it.func == imsf_pkg::FUNC_SET) begin
                if (rows[y][x] != it.spin_value) begin
                    rows[y][x] = it.spin_value;
                    mag += it.spin_value ? 2 : -2;
                end
                r.new_spin = it.spin_value;
            end else begin
                xl   = (x == 0) ? COLS - 1 : x - 1;
                xr   = (x == COLS - 1) ? 0 : x + 1;
                s    = spin_at(x, y);
                nsum = spin_at(xl, y) + spin_at(xr, y) + spin_at(x, y - 1) + spin_at(x, y + 1);
                h    = s * nsum;
                if (int'(it.random_fraction) < int'(thresh[(h + 4) / 2])) begin
                    rows[y][x] = ~rows[y][x];
                    mag += rows[y][x] ? 2 : -2;
                    r.flipped       = 1'b1;
                    r.energy_change = imsf_pkg::ENERGY_W'(2 * h);
                end
                r.new_spin = rows[y][x];
            end
            r.magnetization = imsf_pkg::MAG_W'(mag);
            expected_q.push_back(r);
        endfunction

        function void compare_field(string name, int expv, int actv);
            if (expv != actv) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
            end
        endfunction

        function void check_result(logic [imsf_pkg::OUT_DATA_W-1:0] word);
            t_flip_result got, want;
            got = t_flip_result'(word[imsf_pkg::OUT_BITS-1:0]);
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none, got %h", $time, word);
                return;
            end
            want = expected_q.pop_front();
            compare_field("flipped", want.flipped, got.flipped);
            compare_field("new_spin", want.new_spin, got.new_spin);
            compare_field("energy_change", want.energy_change, got.energy_change);
            compare_field("magnetization", want.magnetization, got.magnetization);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [IN_DATA_W-1:0]            i_s_tdata;
    logic                            i_s_tuser;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [imsf_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [imsf_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [imsf_pkg::THRESH_W-1:0]   i_cfg_data;

    t_spin_flip_scoreboard sb;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int stall_request = 0;

    ising_metropolis_spin_flip u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case a word never shows up
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    // Result side ready: random backpressure, or a long hold when requested
    initial begin : result_ready
        int stall_left;
        stall_left = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_request > 0) begin
                stall_left    = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Check every result word taken
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
    end

    task automatic send_item(input t_spin_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= it.func;
        i_s_tdata  <= {2'b00, it.random_fraction, it.spin_value, it.site_y, it.site_x};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(it);
    endtask

    task automatic write_reg(input int idx, input logic [imsf_pkg::THRESH_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= imsf_pkg::CFG_IDX_W'(idx);
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_threshold(idx, value);
    endtask

    // Drop valid and let every expected word come back
    task automatic drain();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    function automatic t_spin_item make_item(logic func, int x, int y, logic sv, int rnd);
        t_spin_item it;
        it.func            = func;
        it.site_x          = 6'(x);
        it.site_y          = 7'(y);
        it.spin_value      = sv;
        it.random_fraction = 16'(rnd);
        return it;
    endfunction

    // Mostly flips, often near the wrap column and the pinned rows
    function automatic t_spin_item random_item();
        t_spin_item it;
        int pick;
        it.func       = ($urandom_range(99) < 75) ? imsf_pkg::FUNC_FLIP : imsf_pkg::FUNC_SET;
        it.site_x     = $urandom_range(1) ? 6'($urandom_range(63)) : 6'($urandom_range(66, 62));
        pick          = $urandom_range(99);
        if (pick < 6)       it.site_y = 7'($urandom_range(127));
        else if (pick < 30) it.site_y = $urandom_range(1) ? 7'($urandom_range(3, 1))
                                                          : 7'($urandom_range(64, 62));
        else                it.site_y = 7'($urandom_range(64, 1));
        it.spin_value = 1'($urandom_range(1));
        pick          = $urandom_range(19);
        if (pick == 0)      it.random_fraction = 16'h0000;
        else if (pick == 1) it.random_fraction = 16'hFFFF;
        else                it.random_fraction = 16'($urandom_range(65535));
        return it;
    endfunction

    function automatic logic [imsf_pkg::THRESH_W-1:0] random_threshold();
        case ($urandom_range(4))
            0:       return '0;
            1:       return THRESH_ALWAYS;
            2:       return THRESH_MAX;
            default: return imsf_pkg::THRESH_W'($urandom_range(65536));
        endcase
    endfunction

    initial begin : stimulus
        t_spin_item directed [$];
        sb = new();
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tuser   <= 1'b0;
        i_s_tdata   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Start from the reset thresholds, written explicitly
        for (int r = REG_FIELD_MINUS4; r <= REG_FIELD_PLUS4; r++) begin
            write_reg(r, imsf_pkg::THRESH_RESET[r]);
        end
        i_cfg_valid <= 1'b0;

        // Wrap column and the rows next to the pinned boundaries
        directed.push_back(make_item(imsf_pkg::FUNC_SET, 0, 1, 1'b1, 65535));
        directed.push_back(make_item(imsf_pkg::FUNC_SET, 63, 64, 1'b1, 0));
        directed.push_back(make_item(imsf_pkg::FUNC_FLIP, 0, 1, 1'b0, 0));
        directed.push_back(make_item(imsf_pkg::FUNC_FLIP, 63, 64, 1'b1, 65535));
        // Fully aligned site: field +4 at and just below the threshold, then -4
        directed.push_back(make_item(imsf_pkg::FUNC_FLIP, 10, 10, 1'b0, 1200));
        directed.push_back(make_item(imsf_pkg::FUNC_FLIP, 10, 10, 1'b0, 1199));
        directed.push_back(make_item(imsf_pkg::FUNC_FLIP, 10, 10, 1'b1, 65535));
        // Zero field: two up neighbors, two down
        directed.push_back(make_item(imsf_pkg::FUNC_SET, 9, 10, 1'b1, 0));
        directed.push_back(make_item(imsf_pkg::FUNC_SET, 11, 10, 1'b1, 0));
        directed.push_back(make_item(imsf_pkg::FUNC_FLIP, 10, 10, 1'b0, 65535));
        // Field +2 with the upper neighbor raised, both sides of the threshold
        directed.push_back(make_item(imsf_pkg::FUNC_SET, 10, 11, 1'b1, 0));
        directed.push_back(make_item(imsf_pkg::FUNC_FLIP, 10, 10, 1'b1, 8869));
        directed.push_back(make_item(imsf_pkg::FUNC_FLIP, 10, 10, 1'b1, 8868));
        // Field -2 now that the site is down
        directed.push_back(make_item(imsf_pkg::FUNC_FLIP, 10, 10, 1'b0, 65535));
        // Set to the value already held
        directed.push_back(make_item(imsf_pkg::FUNC_SET, 10, 11, 1'b1, 0));
        // Pinned and out-of-range rows are ignored
        directed.push_back(make_item(imsf_pkg::FUNC_FLIP, 5, 0, 1'b1, 0));
        directed.push_back(make_item(imsf_pkg::FUNC_SET, 5, 65, 1'b0, 0));
        directed.push_back(make_item(imsf_pkg::FUNC_FLIP, 5, 66, 1'b1, 0));
        directed.push_back(make_item(imsf_pkg::FUNC_SET, 63, 127, 1'b1, 65535));
        directed.push_back(make_item(imsf_pkg::FUNC_SET, 5, 0, 1'b1, 0));
        foreach (directed[i]) send_item(directed[i]);
        drain();

        for (int phase = 0; phase < 6; phase++) begin
            // New threshold setting while idle
            for (int r = REG_FIELD_MINUS4; r <= REG_FIELD_PLUS4; r++) begin
                case (phase)
                    1:       write_reg(r, '0);
                    2:       write_reg(r, THRESH_MAX);
                    3:       write_reg(r, (r <= REG_FIELD_ZERO)
                                          ? THRESH_ALWAYS
                                          : imsf_pkg::THRESH_W'($urandom_range(65535, 1)));
                    default: write_reg(r, random_threshold());
                endcase
            end
            if (phase == 2) write_reg(REG_UNMAPPED, '0);
            i_cfg_valid <= 1'b0;

            // Idle pattern: receiver idles more, then the sender, then neither
            if (phase < 2) begin
                send_idle_pct = 38;
                recv_idle_pct = 67;
            end else if (phase < 4) begin
                send_idle_pct = 67;
                recv_idle_pct = 38;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // Hold the result side off while words keep coming
                if (phase == 4 && n == 40) stall_request = 300;
                send_item(random_item());
            end
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
